// ===== src/spae_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spae_pkg
// Shared types and codes for the sparse polynomial engine: transaction
// payloads, operation and status codes, and controller/datapath command links.
// ----------------------------------------------------------------------------
package spae_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int COEF_BITS_DEF = 16;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_LOAD1  = 3'd1;
  localparam logic [2:0] OP_LOAD2  = 3'd2;
  localparam logic [2:0] OP_ADD    = 3'd3;
  localparam logic [2:0] OP_SUB    = 3'd4;
  localparam logic [2:0] OP_DERIV1 = 3'd5;
  localparam logic [2:0] OP_DERIV2 = 3'd6;

  localparam logic [1:0] ST_TERM  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ACK   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] coeff;
    logic [7:0]         exponent;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] res_coeff;
    logic [7:0]         res_exponent;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LATCH,
    DP_CLEAR,
    DP_LD_SCAN_RD,
    DP_LD_SCAN_ADV,
    DP_LD_SHIFT_RD,
    DP_LD_SHIFT_WR,
    DP_LD_PUT,
    DP_MG_RD,
    DP_MG_STEP,
    DP_DV_RD,
    DP_DV_STEP,
    DP_EM_START,
    DP_EM_CAP,
    DP_EM_SCAN_RD,
    DP_EM_SCAN_ADV,
    DP_EM_SETP,
    DP_EM_RD,
    DP_EM_OUT,
    DP_OUT_ST
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       zero;
    logic       full;
    logic       scan_go;
    logic       shift_go;
    logic       mg_go;
    logic       dv_go;
    logic       wb_empty;
    logic       scan_more;
    logic       run_eq;
    logic       run_end;
    logic       last;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/spae_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spae_ctrl
// Sequencer for the polynomial engine: load insert, merge, derive and the
// run-reversing emit pass, issued to the datapath one command per cycle.
// ----------------------------------------------------------------------------
module spae_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire spae_pkg::dp_stat_t stat,
  output spae_pkg::dp_cmd_t      cmd
);
  import spae_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LD_SRD, S_LD_SCMP, S_LD_SHRD, S_LD_SHWR, S_LD_PUT,
    S_MG_RD, S_MG_STEP, S_DV_RD, S_DV_STEP, S_EM_CHK, S_EM_START, S_EM_CAP,
    S_EM_SRD, S_EM_SCMP, S_EM_PRD, S_EM_OUT, S_ST_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] st_code_r, st_code_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    st_code_nxt = st_code_r;
    cmd.op      = DP_NONE;
    cmd.st      = st_code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_CLEAR: begin
            cmd.op      = DP_CLEAR;
            st_code_nxt = ST_ACK;
            state_nxt   = S_ST_OUT;
          end
          OP_LOAD1, OP_LOAD2: begin
            if (stat.zero) begin
              st_code_nxt = ST_ACK;
              state_nxt   = S_ST_OUT;
            end else if (stat.full) begin
              st_code_nxt = ST_FULL;
              state_nxt   = S_ST_OUT;
            end else begin
              state_nxt = S_LD_SRD;
            end
          end
          OP_ADD, OP_SUB:     state_nxt = S_MG_RD;
          OP_DERIV1, OP_DERIV2: state_nxt = S_DV_RD;
          default: begin
            st_code_nxt = ST_EMPTY;
            state_nxt   = S_ST_OUT;
          end
        endcase
      end
      S_LD_SRD: begin
        cmd.op    = DP_LD_SCAN_RD;
        state_nxt = S_LD_SCMP;
      end
      S_LD_SCMP: begin
        if (stat.scan_go) begin
          cmd.op    = DP_LD_SCAN_ADV;
          state_nxt = S_LD_SRD;
        end else begin
          state_nxt = S_LD_SHRD;
        end
      end
      S_LD_SHRD: begin
        if (stat.shift_go) begin
          cmd.op    = DP_LD_SHIFT_RD;
          state_nxt = S_LD_SHWR;
        end else begin
          state_nxt = S_LD_PUT;
        end
      end
      S_LD_SHWR: begin
        cmd.op    = DP_LD_SHIFT_WR;
        state_nxt = S_LD_SHRD;
      end
      S_LD_PUT: begin
        if (stat.out_free) begin
          cmd.op    = DP_LD_PUT;
          cmd.st    = ST_ACK;
          state_nxt = S_IDLE;
        end
      end
      S_MG_RD: begin
        if (stat.mg_go) begin
          cmd.op    = DP_MG_RD;
          state_nxt = S_MG_STEP;
        end else begin
          state_nxt = S_EM_CHK;
        end
      end
      S_MG_STEP: begin
        cmd.op    = DP_MG_STEP;
        state_nxt = S_MG_RD;
      end
      S_DV_RD: begin
        if (stat.dv_go) begin
          cmd.op    = DP_DV_RD;
          state_nxt = S_DV_STEP;
        end else begin
          state_nxt = S_EM_CHK;
        end
      end
      S_DV_STEP: begin
        cmd.op    = DP_DV_STEP;
        state_nxt = S_DV_RD;
      end
      S_EM_CHK: begin
        if (stat.wb_empty) begin
          st_code_nxt = ST_EMPTY;
          state_nxt   = S_ST_OUT;
        end else begin
          state_nxt = S_EM_START;
        end
      end
      S_EM_START: begin
        cmd.op    = DP_EM_START;
        state_nxt = S_EM_CAP;
      end
      S_EM_CAP: begin
        cmd.op    = DP_EM_CAP;
        state_nxt = S_EM_SRD;
      end
      S_EM_SRD: begin
        if (stat.scan_more) begin
          cmd.op    = DP_EM_SCAN_RD;
          state_nxt = S_EM_SCMP;
        end else begin
          cmd.op    = DP_EM_SETP;
          state_nxt = S_EM_PRD;
        end
      end
      S_EM_SCMP: begin
        if (stat.run_eq) begin
          cmd.op    = DP_EM_SCAN_ADV;
          state_nxt = S_EM_SRD;
        end else begin
          cmd.op    = DP_EM_SETP;
          state_nxt = S_EM_PRD;
        end
      end
      S_EM_PRD: begin
        cmd.op    = DP_EM_RD;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (stat.out_free) begin
          cmd.op = DP_EM_OUT;
          if (stat.last)         state_nxt = S_IDLE;
          else if (stat.run_end) state_nxt = S_EM_START;
          else                   state_nxt = S_EM_PRD;
        end
      end
      S_ST_OUT: begin
        if (stat.out_free) begin
          cmd.op    = DP_OUT_ST;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      st_code_r <= ST_ACK;
    end else begin
      state_r   <= state_nxt;
      st_code_r <= st_code_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/spae_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spae_dp
// Datapath: two sorted term stores, the merge/derive arithmetic, a work
// buffer of result terms, walk pointers and the output register.
// ----------------------------------------------------------------------------
module spae_dp #(
  parameter int MAX_TERMS = spae_pkg::MAX_TERMS_DEF,
  parameter int COEF_BITS = spae_pkg::COEF_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spae_pkg::in_item_t in_data,
  input  wire spae_pkg::dp_cmd_t  cmd,
  output spae_pkg::dp_stat_t      stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spae_pkg::out_item_t     out_data
);
  import spae_pkg::*;

  localparam int IW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW  = $clog2(MAX_TERMS + 1);
  localparam int WAW = $clog2(2 * MAX_TERMS);
  localparam int WCW = $clog2(2 * MAX_TERMS + 1);
  localparam int SW  = COEF_BITS + 8;
  localparam int EW  = (COEF_BITS + 9 > 25) ? COEF_BITS + 9 : 25;
  localparam logic signed [EW-1:0] RHI = EW'(8388607);
  localparam logic signed [EW-1:0] RLO = -RHI - EW'(1);
  localparam logic signed [32:0]   CHI = 33'((64'sd1 <<< (COEF_BITS - 1)) - 64'sd1);
  localparam logic signed [32:0]   CLO = -CHI - 33'sd1;

  logic [SW-1:0] st1_mem [MAX_TERMS];
  logic [SW-1:0] st2_mem [MAX_TERMS];
  logic [31:0]   wb_mem  [2*MAX_TERMS];

  logic [SW-1:0]  rd1_r, rd2_r;
  logic [31:0]    wrd_r;
  in_item_t       in_r;
  logic [7:0]     run_exp_r;
  out_item_t      out_r;
  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  cnt1_r, cnt1_nxt, cnt2_r, cnt2_nxt;
  logic [CW-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [WCW-1:0] n_r, n_nxt, rs_r, rs_nxt, re_r, re_nxt, rend_r, rend_nxt, k_r, k_nxt;

  logic          sel;
  logic [CW-1:0] cnt_sel, jm;
  logic [SW-1:0] rd_sel;
  logic [IW-1:0] ra1, ra2, wa;
  logic [SW-1:0] swd;
  logic          we1, we2;

  assign sel     = (in_r.op == OP_LOAD2) || (in_r.op == OP_DERIV2);
  assign cnt_sel = sel ? cnt2_r : cnt1_r;
  assign rd_sel  = sel ? rd2_r : rd1_r;
  assign jm      = j_r - CW'(1);

  // saturated load coefficient
  logic signed [32:0] cx, csat;
  always_comb begin
    cx   = 33'(in_r.coeff);
    csat = (cx > CHI) ? CHI : ((cx < CLO) ? CLO : cx);
  end

  always_comb begin
    ra1 = i_r[IW-1:0];
    ra2 = i_r[IW-1:0];
    if (cmd.op == DP_MG_RD) ra2 = j_r[IW-1:0];
    if (cmd.op == DP_LD_SHIFT_RD) begin
      ra1 = jm[IW-1:0];
      ra2 = jm[IW-1:0];
    end
    if (cmd.op == DP_LD_PUT) begin
      wa  = i_r[IW-1:0];
      swd = {csat[COEF_BITS-1:0], in_r.exponent};
    end else begin
      wa  = j_r[IW-1:0];
      swd = rd_sel;
    end
    we1 = ((cmd.op == DP_LD_SHIFT_WR) || (cmd.op == DP_LD_PUT)) && !sel;
    we2 = ((cmd.op == DP_LD_SHIFT_WR) || (cmd.op == DP_LD_PUT)) && sel;
  end

  always_ff @(posedge clk) begin
    if (we1) st1_mem[wa] <= swd;
    rd1_r <= st1_mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (we2) st2_mem[wa] <= swd;
    rd2_r <= st2_mem[ra2];
  end

  // merge and derive arithmetic
  logic signed [COEF_BITS-1:0] c1, c2, cs;
  logic [7:0]                  e1, e2, es;
  logic signed [EW-1:0]        a1, b2, prod, val, vsat;
  logic [7:0]                  vexp;
  logic                        has1, has2, adv_i, adv_j, wv;

  always_comb begin
    c1   = rd1_r[SW-1:8];
    e1   = rd1_r[7:0];
    c2   = rd2_r[SW-1:8];
    e2   = rd2_r[7:0];
    cs   = rd_sel[SW-1:8];
    es   = rd_sel[7:0];
    has1 = i_r < cnt1_r;
    has2 = j_r < cnt2_r;
    a1   = EW'(c1);
    b2   = (in_r.op == OP_SUB) ? -EW'(c2) : EW'(c2);
    prod = EW'(cs) * EW'($signed({1'b0, es}));
    adv_i = 1'b0;
    adv_j = 1'b0;
    if (cmd.op == DP_DV_STEP) begin
      val   = prod;
      vexp  = (es == 8'd0) ? 8'd0 : es - 8'd1;
      adv_i = 1'b1;
    end else if (has1 && has2 && (e1 == e2)) begin
      val   = a1 + b2;
      vexp  = e1;
      adv_i = 1'b1;
      adv_j = 1'b1;
    end else if (!has2 || (has1 && (e1 > e2))) begin
      val   = a1;
      vexp  = e1;
      adv_i = 1'b1;
    end else begin
      val   = b2;
      vexp  = e2;
      adv_j = 1'b1;
    end
    vsat = (val > RHI) ? RHI : ((val < RLO) ? RLO : val);
    wv   = ((cmd.op == DP_MG_STEP) || (cmd.op == DP_DV_STEP)) && (val != '0);
  end

  // work buffer of nonzero result terms
  logic [WCW-1:0] rend_p1, wra;
  assign rend_p1 = rend_r + WCW'(1);

  always_comb begin
    case (cmd.op)
      DP_EM_START:   wra = rs_r;
      DP_EM_SCAN_RD: wra = rend_p1;
      default:       wra = re_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wv) wb_mem[n_r[WAW-1:0]] <= {vsat[23:0], vexp};
    wrd_r <= wb_mem[wra[WAW-1:0]];
  end

  // pointer and count updates
  always_comb begin
    cnt1_nxt      = cnt1_r;
    cnt2_nxt      = cnt2_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    rs_nxt        = rs_r;
    re_nxt        = re_r;
    rend_nxt      = rend_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (cmd.op)
      DP_LATCH: begin
        i_nxt  = '0;
        // loads shift down from the count; merge walks store two from its head
        j_nxt  = (in_data.op == OP_LOAD2) ? cnt2_r :
                 ((in_data.op == OP_LOAD1) ? cnt1_r : '0);
        n_nxt  = '0;
        rs_nxt = '0;
        k_nxt  = '0;
      end
      DP_CLEAR: begin
        cnt1_nxt = '0;
        cnt2_nxt = '0;
      end
      DP_LD_SCAN_ADV: i_nxt = i_r + CW'(1);
      DP_LD_SHIFT_WR: j_nxt = jm;
      DP_LD_PUT: begin
        if (sel) cnt2_nxt = cnt2_r + CW'(1);
        else     cnt1_nxt = cnt1_r + CW'(1);
        out_valid_nxt = 1'b1;
      end
      DP_MG_STEP, DP_DV_STEP: begin
        i_nxt = i_r + CW'(adv_i);
        j_nxt = j_r + CW'(adv_j);
        n_nxt = n_r + WCW'(wv);
      end
      DP_EM_START:    rend_nxt = rs_r;
      DP_EM_SCAN_ADV: rend_nxt = rend_p1;
      DP_EM_SETP:     re_nxt   = rend_r;
      DP_EM_OUT: begin
        out_valid_nxt = 1'b1;
        k_nxt         = k_r + WCW'(1);
        if (re_r == rs_r) rs_nxt = rend_p1;
        else              re_nxt = re_r - WCW'(1);
      end
      DP_OUT_ST: out_valid_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      n_r         <= '0;
      rs_r        <= '0;
      re_r        <= '0;
      rend_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt1_r      <= cnt1_nxt;
      cnt2_r      <= cnt2_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      n_r         <= n_nxt;
      rs_r        <= rs_nxt;
      re_r        <= re_nxt;
      rend_r      <= rend_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  logic [WCW:0] k_p1;
  assign k_p1 = {1'b0, k_r} + (WCW+1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LATCH) in_r <= in_data;
    if (cmd.op == DP_EM_CAP) run_exp_r <= wrd_r[7:0];
    case (cmd.op)
      DP_LD_PUT, DP_OUT_ST: begin
        out_r.res_coeff    <= '0;
        out_r.res_exponent <= '0;
        out_r.status       <= cmd.st;
        out_r.last         <= 1'b1;
      end
      DP_EM_OUT: begin
        out_r.res_coeff    <= wrd_r[31:8];
        out_r.res_exponent <= wrd_r[7:0];
        out_r.status       <= ST_TERM;
        out_r.last         <= (k_p1 == {1'b0, n_r});
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    stat.op        = in_r.op;
    stat.zero      = (in_r.coeff == '0);
    stat.full      = (cnt_sel == CW'(MAX_TERMS));
    stat.scan_go   = (i_r < cnt_sel) && (rd_sel[7:0] > in_r.exponent);
    stat.shift_go  = (j_r > i_r);
    stat.mg_go     = has1 || has2;
    stat.dv_go     = (i_r < cnt_sel);
    stat.wb_empty  = (n_r == '0);
    stat.scan_more = ({1'b0, rend_p1} < {1'b0, n_r});
    stat.run_eq    = (wrd_r[7:0] == run_exp_r);
    stat.run_end   = (re_r == rs_r);
    stat.last      = (k_p1 == {1'b0, n_r});
    stat.out_free  = !out_valid_r || out_ready;
  end

  a_cnt1_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt1_r <= CW'(MAX_TERMS)) else $error("store one count overflow");
  a_cnt2_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt2_r <= CW'(MAX_TERMS)) else $error("store two count overflow");
  a_wb_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, n_r} <= (WCW+1)'(cnt1_r) + (WCW+1)'(cnt2_r))
    else $error("work buffer holds more terms than the stores");
  a_term_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == ST_TERM)) |-> (out_r.res_coeff != '0))
    else $error("zero coefficient term emitted");

endmodule
`default_nettype wire

// ===== src/sparse_polynomial_arith_engine_unit.sv =====
`default_nettype none
// Clear and status-only transactions pass through dispatch to the output register.
// Load: scan past larger exponents, shift the later entries, then put the new term.
// Add/subtract/derive: walk stored terms into the work buffer, then per result run
// scan the run and emit its terms in reverse order.
// One transaction at a time; in_ready is high only while the controller is idle.
// Reset clears counts and control; term stores and work buffer are not cleared.
// ----------------------------------------------------------------------------
// sparse_polynomial_arith_engine_unit
// Top level: sparse polynomial load, add, subtract and derive engine.
// ----------------------------------------------------------------------------
module sparse_polynomial_arith_engine_unit #(
  parameter int MAX_TERMS = spae_pkg::MAX_TERMS_DEF,
  parameter int COEF_BITS = spae_pkg::COEF_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire spae_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output spae_pkg::out_item_t      out_data
);
  import spae_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spae_dp #(
    .MAX_TERMS (MAX_TERMS),
    .COEF_BITS (COEF_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
